// ----- sv/wgs_pkg.sv -----
package wgs_pkg;

   // grid geometry
   localparam int MAX_ROWS     = 128;
   localparam int MAX_COLS     = 128;
   localparam int HEIGHT_WIDTH = 16;
   localparam int ROW_W        = $clog2(MAX_ROWS);
   localparam int COL_W        = $clog2(MAX_COLS);
   localparam int ADDR_W       = ROW_W + COL_W;
   localparam int CELLS        = MAX_ROWS * MAX_COLS;

   // field and register widths
   localparam int DIM_W      = 8;
   localparam int COEF_W     = 19;
   localparam int STEP_W     = 16;
   localparam int MAG_W      = 16;
   localparam int DIR_W      = 16;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 96;

   // datapath widths
   localparam int NSUM_W = HEIGHT_WIDTH + 2;
   localparam int MUL_W  = 22;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 40;
   localparam int VEC_W  = 21;
   localparam int SQS_W  = 44;
   localparam int ROOT_W = 22;
   localparam int QUO_W  = 15;
   localparam int REM_W  = 24;
   localparam int NUM_W  = VEC_W + QUO_W + 1;
   localparam int PH_W   = 4;
   localparam int NDIR   = 5;
   localparam int DIDX_W = 3;

   localparam logic [SQS_W-1:0] ROOT_TOP = SQS_W'(1) << (2 * (ROOT_W - 1));
   localparam logic [DIR_W-1:0] ONE_Q14  = DIR_W'(16384);

   typedef enum logic [CMD_W-1:0] {
      CMD_STEP    = 2'd0,
      CMD_DISTURB = 2'd1,
      CMD_READ    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_K_PREV   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_K_SELF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_K_NEIGH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING  = 3'd5;

   localparam logic [DIM_W-1:0]         ROWS_RST    = DIM_W'(MAX_ROWS);
   localparam logic [DIM_W-1:0]         COLS_RST    = DIM_W'(MAX_COLS);
   localparam logic signed [COEF_W-1:0] K_PREV_RST  = -19'sd65536;
   localparam logic signed [COEF_W-1:0] K_SELF_RST  = 19'sd131072;
   localparam logic signed [COEF_W-1:0] K_NEIGH_RST = 19'sd0;
   localparam logic [STEP_W-1:0]        SPACING_RST = 16'd256;

   // neighbour order used by the cell walks
   localparam logic [2:0] NB_UP     = 3'd0;
   localparam logic [2:0] NB_DOWN   = 3'd1;
   localparam logic [2:0] NB_LEFT   = 3'd2;
   localparam logic [2:0] NB_RIGHT  = 3'd3;
   localparam logic [2:0] NB_CENTRE = 3'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_STEP,
      ST_DIST,
      ST_FETCH,
      ST_SQUARE,
      ST_ROOT,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

endpackage

// ----- sv/wgs_ram.sv -----
module wgs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/wave_grid_stencil_step.sv -----
// throughput: one item at a time; a step is bound by the single bank read port, a read by
// the shared bit-serial square root and divider
// reset: synchronous, resets the control and configuration registers, then a clearing pass over
// all 16384 cells zeroes both banks with req_tready low
module wave_grid_stencil_step (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wgs_pkg::REQ_DATA_W-1:0]     req_tdata,  // row[6:0], col[13:7], magnitude[29:14]
   input  logic [wgs_pkg::CMD_W-1:0]          req_tuser,  // command[1:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wgs_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // height, normal_x, normal_y, normal_z,
                                                          // tangent_x, tangent_y, 16 bits each
   output logic [0:0]                         rsp_tuser,  // status[0]
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wgs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wgs_pkg::CSR_DATA_W-1:0]     csr_data
);

   import wgs_pkg::*;

   localparam logic signed [ACC_W-1:0] H_MAX = ACC_W'((1 << (HEIGHT_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] H_MIN = ~H_MAX;
   localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) << 15;

   function automatic logic [HEIGHT_WIDTH-1:0] sat_h(input logic signed [ACC_W-1:0] v);
      logic [HEIGHT_WIDTH-1:0] r;
      if (v > H_MAX) begin
         r = H_MAX[HEIGHT_WIDTH-1:0];
      end else if (v < H_MIN) begin
         r = H_MIN[HEIGHT_WIDTH-1:0];
      end else begin
         r = v[HEIGHT_WIDTH-1:0];
      end
      return r;
   endfunction

   // control
   state_type state_ff, state_in;
   logic [PH_W-1:0]   ph_ff, ph_in;
   logic [ADDR_W-1:0] clr_ff;
   logic              cur_ff;

   // configuration
   logic [DIM_W-1:0]         rows_ff, cols_ff;
   logic signed [COEF_W-1:0] kp_ff, ks_ff, kn_ff;
   logic [STEP_W-1:0]        dx_ff;

   // item
   cmd_type                  cmd_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [COL_W-1:0]         col_ff;
   logic signed [MAG_W-1:0]  mag_ff;

   // stencil datapath
   logic signed [NSUM_W-1:0]       nsum_ff;
   logic signed [HEIGHT_WIDTH-1:0] cu_ff, pv_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [MUL_W-1:0]        mul_a, mul_b;

   // read datapath
   logic signed [HEIGHT_WIDTH-1:0] t_ff, b_ff, l_ff, rt_ff;
   logic [SQS_W-1:0]  sqa_ff, sumt_ff, root_v_ff, root_res_ff, root_bit_ff;
   logic              root_sel_ff;
   logic [ROOT_W-1:0] nn_ff, nt_ff;
   logic [DIDX_W-1:0] div_idx_ff;
   logic [PH_W-1:0]   div_cnt_ff;
   logic [REM_W-1:0]  div_rem_ff;
   logic [QUO_W-1:0]  div_low_ff, div_q_ff;

   // result
   logic                           res_status_ff;
   logic signed [HEIGHT_WIDTH-1:0] res_height_ff;
   logic [DIR_W-1:0]               res_dir_ff [NDIR];
   logic                           rsp_valid_ff;
   logic                           rsp_status_ff;
   logic [RSP_DATA_W-1:0]          rsp_data_ff;

   // memories
   logic [ADDR_W-1:0]              a_rd_addr, b_rd_addr, wr_addr, cur_addr, ctr_addr;
   logic [HEIGHT_WIDTH-1:0]        a_q, b_q, wr_data;
   logic                           a_we, b_we, wr_cur, wr_prv;
   logic signed [HEIGHT_WIDTH-1:0] cur_q, prv_q, cur_m;
   logic [2:0]                     nb_sel;

   // grid geometry and cell checks
   logic [DIM_W-1:0] grid_r, grid_c;
   logic [DIM_W:0]   rw, cw, r9, c9;
   logic up_ok, down_ok, left_ok, right_ok, inner_ok, dist_ok, in_grid, has_inner;
   logic last_col, last_row, nb_ok;

   logic req_acc, rsp_free;

   assign grid_r = (rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ff;
   assign grid_c = (cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ff;
   assign rw = (DIM_W + 1)'(row_ff);
   assign cw = (DIM_W + 1)'(col_ff);
   assign r9 = (DIM_W + 1)'(grid_r);
   assign c9 = (DIM_W + 1)'(grid_c);

   assign up_ok     = rw >= 9'd2;
   assign down_ok   = (rw + 9'd3) <= r9;
   assign left_ok   = cw >= 9'd2;
   assign right_ok  = (cw + 9'd3) <= c9;
   assign inner_ok  = (rw >= 9'd1) && ((rw + 9'd2) <= r9) && (cw >= 9'd1) && ((cw + 9'd2) <= c9);
   assign dist_ok   = up_ok && down_ok && left_ok && right_ok;
   assign in_grid   = (rw < r9) && (cw < c9);
   assign has_inner = (r9 >= 9'd3) && (c9 >= 9'd3);
   assign last_col  = (cw + 9'd3) > c9;
   assign last_row  = (rw + 9'd3) > r9;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // read-side difference vectors
   logic signed [HEIGHT_WIDTH:0] d_lr, d_bt;
   logic [VEC_W-1:0]             m0, m1, m2, div_m;
   logic [STEP_W-1:0]            dx_eff;
   logic [ROOT_W-1:0]            div_n;
   logic                         div_neg;

   assign d_lr   = (HEIGHT_WIDTH + 1)'(l_ff) - (HEIGHT_WIDTH + 1)'(rt_ff);
   assign d_bt   = (HEIGHT_WIDTH + 1)'(b_ff) - (HEIGHT_WIDTH + 1)'(t_ff);
   assign m0     = VEC_W'(d_lr[HEIGHT_WIDTH] ? -d_lr : d_lr);
   assign m2     = VEC_W'(d_bt[HEIGHT_WIDTH] ? -d_bt : d_bt);
   assign dx_eff = (dx_ff == '0) ? STEP_W'(1) : dx_ff;
   assign m1     = {dx_eff, 5'b0};

   // which magnitude and norm each division uses: nx, ny, nz, tx, ty
   always_comb begin
      div_m   = m0;
      div_n   = nn_ff;
      div_neg = 1'b0;
      case (div_idx_ff)
         3'd0: begin
            div_m   = m0;
            div_neg = d_lr < 0;
         end
         3'd1: begin
            div_m = m1;
         end
         3'd2: begin
            div_m   = m2;
            div_neg = d_bt < 0;
         end
         3'd3: begin
            div_m = m1;
            div_n = nt_ff;
         end
         default: begin
            div_m   = m0;
            div_n   = nt_ff;
            div_neg = d_lr > 0;
         end
      endcase
   end

   // square root step
   logic [SQS_W-1:0] root_try, root_res_nx, root_v_nx;
   logic             root_ge;
   assign root_try    = root_res_ff + root_bit_ff;
   assign root_ge     = root_v_ff >= root_try;
   assign root_res_nx = root_ge ? ((root_res_ff >> 1) + root_bit_ff) : (root_res_ff >> 1);
   assign root_v_nx   = root_ge ? (root_v_ff - root_try) : root_v_ff;

   // restoring divide step
   logic [NUM_W-1:0]  div_num;
   logic [ROOT_W:0]   div_den;
   logic [REM_W:0]    div_trial;
   logic              div_ge;
   logic [QUO_W-1:0]  div_q_nx;
   logic [DIR_W-1:0]  div_out;
   assign div_num   = NUM_W'({div_m, QUO_W'(0)}) + NUM_W'(div_n);
   assign div_den   = {div_n, 1'b0};
   assign div_trial = {div_rem_ff, div_low_ff[QUO_W-1]};
   assign div_ge    = div_trial >= (REM_W + 1)'(div_den);
   assign div_q_nx  = {div_q_ff[QUO_W-2:0], div_ge};
   assign div_out   = div_neg ? -DIR_W'(div_q_nx) : DIR_W'(div_q_nx);

   // stencil result
   logic signed [ACC_W-1:0] acc_sum, acc_rnd;
   assign acc_sum = acc_ff + ACC_W'(prod_ff);
   assign acc_rnd = (acc_sum + RND) >>> 16;

   // next state
   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff + PH_W'(1);
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff)
               CMD_STEP:    state_in = has_inner ? ST_STEP : ST_DONE;
               CMD_DISTURB: state_in = dist_ok ? ST_DIST : ST_DONE;
               CMD_READ:    state_in = (in_grid && inner_ok) ? ST_FETCH : ST_DONE;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_STEP: begin
            if (ph_ff == PH_W'(8)) begin
               ph_in = '0;
               if (last_col && last_row) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIST: begin
            if (ph_ff == PH_W'(9)) begin
               state_in = ST_DONE;
            end
         end
         ST_FETCH: begin
            if (ph_ff == PH_W'(5)) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (ph_ff == PH_W'(3)) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_bit_ff[0] && root_sel_ff) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_cnt_ff == PH_W'(QUO_W - 1)) begin
               state_in = (div_idx_ff == DIDX_W'(NDIR - 1)) ? ST_DONE : ST_DIV_LOAD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (state_in != state_ff) begin
         ph_in = '0;
      end
   end

   // neighbour address of the cell being worked on
   always_comb begin
      ctr_addr = {row_ff, col_ff};
      case (nb_sel)
         NB_UP:    cur_addr = {row_ff - ROW_W'(1), col_ff};
         NB_DOWN:  cur_addr = {row_ff + ROW_W'(1), col_ff};
         NB_LEFT:  cur_addr = {row_ff, col_ff - COL_W'(1)};
         NB_RIGHT: cur_addr = {row_ff, col_ff + COL_W'(1)};
         default:  cur_addr = ctr_addr;
      endcase
   end

   // data beat from the current bank with boundary cells read as zero
   always_comb begin
      case (ph_ff)
         PH_W'(1): nb_ok = up_ok;
         PH_W'(2): nb_ok = down_ok;
         PH_W'(3): nb_ok = left_ok;
         PH_W'(4): nb_ok = right_ok;
         default:  nb_ok = 1'b1;
      endcase
   end

   assign cur_q = cur_ff ? b_q : a_q;
   assign prv_q = cur_ff ? a_q : b_q;
   assign cur_m = nb_ok ? cur_q : '0;

   // outputs: memory ports and multiplier operands
   always_comb begin
      nb_sel  = (state_ff == ST_DIST) ? ph_ff[3:1] : ph_ff[2:0];
      wr_cur  = 1'b0;
      wr_prv  = 1'b0;
      wr_addr = ctr_addr;
      wr_data = '0;
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_addr = clr_ff;
         end
         ST_STEP: begin
            case (ph_ff)
               PH_W'(5): begin
                  mul_a = MUL_W'(kn_ff);
                  mul_b = MUL_W'(nsum_ff);
               end
               PH_W'(6): begin
                  mul_a = MUL_W'(ks_ff);
                  mul_b = MUL_W'(cu_ff);
               end
               PH_W'(7): begin
                  mul_a = MUL_W'(kp_ff);
                  mul_b = MUL_W'(pv_ff);
               end
               PH_W'(8): begin
                  wr_prv  = 1'b1;
                  wr_data = sat_h(acc_rnd);
               end
               default: begin
                  mul_a = '0;
               end
            endcase
         end
         ST_DIST: begin
            wr_addr = cur_addr;
            if (ph_ff[0]) begin
               wr_cur  = 1'b1;
               wr_data = sat_h(ACC_W'(cur_q) +
                               ((nb_sel == NB_CENTRE) ? ACC_W'(mag_ff) : ACC_W'(mag_ff >>> 1)));
            end
         end
         ST_SQUARE: begin
            case (ph_ff)
               PH_W'(0): begin
                  mul_a = MUL_W'(m0);
                  mul_b = MUL_W'(m0);
               end
               PH_W'(1): begin
                  mul_a = MUL_W'(m1);
                  mul_b = MUL_W'(m1);
               end
               default: begin
                  mul_a = MUL_W'(m2);
                  mul_b = MUL_W'(m2);
               end
            endcase
         end
         default: begin
            wr_data = '0;
         end
      endcase
   end

   assign a_rd_addr = cur_ff ? ctr_addr : cur_addr;
   assign b_rd_addr = cur_ff ? cur_addr : ctr_addr;
   assign a_we = (state_ff == ST_CLEAR) || (cur_ff ? wr_prv : wr_cur);
   assign b_we = (state_ff == ST_CLEAR) || (cur_ff ? wr_cur : wr_prv);

   wgs_ram #(.WIDTH(HEIGHT_WIDTH), .DEPTH(CELLS)) u_bank_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_q)
   );

   wgs_ram #(.WIDTH(HEIGHT_WIDTH), .DEPTH(CELLS)) u_bank_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_q)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ph_ff        <= '0;
         clr_ff       <= '0;
         cur_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= ROWS_RST;
         cols_ff      <= COLS_RST;
         kp_ff        <= K_PREV_RST;
         ks_ff        <= K_SELF_RST;
         kn_ff        <= K_NEIGH_RST;
         dx_ff        <= SPACING_RST;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         // roles of the banks swap once a step has swept the interior, or at once when the grid has no interior
         if ((state_ff == ST_DECODE && cmd_ff == CMD_STEP && !has_inner) ||
             (state_ff == ST_STEP && ph_ff == PH_W'(8) && last_col && last_row)) begin
            cur_ff <= !cur_ff;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS:    rows_ff <= csr_data[DIM_W-1:0];
               CSR_COLS:    cols_ff <= csr_data[DIM_W-1:0];
               CSR_K_PREV:  kp_ff   <= csr_data;
               CSR_K_SELF:  ks_ff   <= csr_data;
               CSR_K_NEIGH: kn_ff   <= csr_data;
               CSR_SPACING: dx_ff   <= csr_data[STEP_W-1:0];
               default:     dx_ff   <= dx_ff;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= {res_dir_ff[4], res_dir_ff[3], res_dir_ff[2],
                           res_dir_ff[1], res_dir_ff[0], res_height_ff};
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cmd_ff <= cmd_type'(req_tuser);
               row_ff <= req_tdata[ROW_W-1:0];
               col_ff <= req_tdata[ROW_W+COL_W-1:ROW_W];
               mag_ff <= req_tdata[ROW_W+COL_W+MAG_W-1:ROW_W+COL_W];
            end
         end
         ST_DECODE: begin
            res_status_ff <= 1'b0;
            res_height_ff <= '0;
            for (int i = 0; i < NDIR; i++) begin
               res_dir_ff[i] <= '0;
            end
            case (cmd_ff)
               CMD_STEP: begin
                  row_ff <= ROW_W'(1);
                  col_ff <= COL_W'(1);
               end
               CMD_DISTURB: begin
                  res_status_ff <= !dist_ok;
               end
               CMD_READ: begin
                  if (!in_grid) begin
                     res_status_ff <= 1'b1;
                  end else if (!inner_ok) begin
                     // flat surface at a boundary cell
                     res_dir_ff[1] <= ONE_Q14;
                     res_dir_ff[3] <= ONE_Q14;
                  end
               end
               default: begin
                  res_status_ff <= 1'b1;
               end
            endcase
         end
         ST_STEP: begin
            case (ph_ff)
               PH_W'(1): nsum_ff <= NSUM_W'(cur_m);
               PH_W'(2), PH_W'(3), PH_W'(4): nsum_ff <= nsum_ff + NSUM_W'(cur_m);
               PH_W'(5): begin
                  cu_ff <= cur_q;
                  pv_ff <= prv_q;
               end
               PH_W'(6): acc_ff <= ACC_W'(prod_ff);
               PH_W'(7): acc_ff <= acc_sum;
               PH_W'(8): begin
                  if (last_col) begin
                     col_ff <= COL_W'(1);
                     row_ff <= row_ff + ROW_W'(1);
                  end else begin
                     col_ff <= col_ff + COL_W'(1);
                  end
               end
               default: begin
                  acc_ff <= acc_ff;
               end
            endcase
         end
         ST_FETCH: begin
            case (ph_ff)
               PH_W'(1): t_ff          <= cur_m;
               PH_W'(2): b_ff          <= cur_m;
               PH_W'(3): l_ff          <= cur_m;
               PH_W'(4): rt_ff         <= cur_m;
               PH_W'(5): res_height_ff <= cur_q;
               default:  t_ff          <= t_ff;
            endcase
         end
         ST_SQUARE: begin
            case (ph_ff)
               PH_W'(1): sqa_ff  <= SQS_W'(prod_ff);
               PH_W'(2): sumt_ff <= sqa_ff + SQS_W'(prod_ff);
               PH_W'(3): begin
                  root_v_ff   <= sumt_ff + SQS_W'(prod_ff);
                  root_res_ff <= '0;
                  root_bit_ff <= ROOT_TOP;
                  root_sel_ff <= 1'b0;
               end
               default: sqa_ff <= sqa_ff;
            endcase
         end
         ST_ROOT: begin
            if (root_bit_ff[0]) begin
               if (!root_sel_ff) begin
                  nn_ff       <= root_res_nx[ROOT_W-1:0];
                  root_v_ff   <= sumt_ff;
                  root_res_ff <= '0;
                  root_bit_ff <= ROOT_TOP;
                  root_sel_ff <= 1'b1;
               end else begin
                  nt_ff      <= root_res_nx[ROOT_W-1:0];
                  div_idx_ff <= '0;
               end
            end else begin
               root_v_ff   <= root_v_nx;
               root_res_ff <= root_res_nx;
               root_bit_ff <= root_bit_ff >> 2;
            end
         end
         ST_DIV_LOAD: begin
            div_rem_ff <= REM_W'(div_num[NUM_W-1:QUO_W]);
            div_low_ff <= div_num[QUO_W-1:0];
            div_q_ff   <= '0;
            div_cnt_ff <= '0;
         end
         ST_DIV_RUN: begin
            div_rem_ff <= div_ge ? REM_W'(div_trial - (REM_W + 1)'(div_den))
                                 : REM_W'(div_trial);
            div_low_ff <= div_low_ff << 1;
            div_q_ff   <= div_q_nx;
            div_cnt_ff <= div_cnt_ff + PH_W'(1);
            if (div_cnt_ff == PH_W'(QUO_W - 1)) begin
               res_dir_ff[div_idx_ff] <= div_out;
               div_idx_ff             <= div_idx_ff + DIDX_W'(1);
            end
         end
         default: begin
            cmd_ff <= cmd_ff;
         end
      endcase
   end

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
